FILE: hdl/rgba_max_pool_2x2_defines.svh
// Assertion macros for the port-level checker of the RGBA 2x2 max pool.
// Depends on nothing; each macro expects clk in scope, and RGBAMP_ASSERT also rst.
`ifndef RGBA_MAX_POOL_2X2_DEFINES_SVH
`define RGBA_MAX_POOL_2X2_DEFINES_SVH

// check a property at every rising edge, skipped while reset is high
`define RGBAMP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check a property at every rising edge, reset included
`define RGBAMP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/rgbamp_pkg.sv
// Shared types, constants and the channel maximum function of the RGBA 2x2 max pool.
// Depends on nothing.
package rgbamp_pkg;

  localparam int DEF_MAX_WIDTH   = 1024;
  localparam int HEIGHT_LIMIT    = 4096;
  localparam int WIDTH_W         = 11;
  localparam int HEIGHT_W        = 13;
  localparam int ROW_W           = 12;
  localparam int CFG_W           = 13;
  localparam int PIX_W           = 32;
  localparam int CHANNELS        = 4;
  localparam int CHAN_W          = 8;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

  typedef enum logic {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic odd_col;
    logic odd_row;
    logic row_end;
    logic frame_end;
  } pos_info_t;

  function automatic logic [PIX_W-1:0] chan_max(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
    logic [PIX_W-1:0]  r;
    logic [CHAN_W-1:0] x;
    logic [CHAN_W-1:0] y;
    r = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      x = a[c*CHAN_W +: CHAN_W];
      y = b[c*CHAN_W +: CHAN_W];
      r[c*CHAN_W +: CHAN_W] = (x > y) ? x : y;
    end
    return r;
  endfunction

endpackage

FILE: hdl/rgbamp_pos.sv
// Configuration registers and raster position counters of the RGBA 2x2 max pool.
// Depends on rgbamp_pkg.
module rgbamp_pos #(
  parameter int MAX_WIDTH = rgbamp_pkg::DEF_MAX_WIDTH,
  parameter int AW        = 9
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  rgbamp_pkg::cfg_index_t     cfg_index,
  input  logic [rgbamp_pkg::CFG_W-1:0] cfg_data,
  input  logic                       advance,
  output logic [AW-1:0]              idx,
  output rgbamp_pkg::pos_info_t      info
);
  import rgbamp_pkg::*;

  localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int EW = $clog2(MAX_WIDTH + 1);
  localparam int ZW = (EW > WIDTH_W) ? EW : WIDTH_W;
  localparam int HW = HEIGHT_W;

  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;
  logic [CW-1:0]       col;
  logic [ROW_W-1:0]    row;
  logic [CW-1:0]       col_next;
  logic [ROW_W-1:0]    row_next;

  logic [ZW-1:0] wz;
  logic [EW-1:0] w;
  logic [HW-1:0] h;
  logic [CW-1:0] c0;
  logic [HW-1:0] r1;
  logic [HW-1:0] r0;
  logic [HW-1:0] rn;
  logic [EW-1:0] cn;
  logic [EW-1:0] half_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= WIDTH_RESET;
      height_reg <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  width_reg  <= cfg_data[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    wz = ZW'(width_reg);
    if (wz < ZW'(2)) begin
      w = EW'(2);
    end else if (wz > ZW'(MAX_WIDTH)) begin
      w = EW'(MAX_WIDTH);
    end else begin
      w = EW'(wz);
    end
    if (height_reg < HW'(2)) begin
      h = HW'(2);
    end else if (height_reg > HW'(HEIGHT_LIMIT)) begin
      h = HW'(HEIGHT_LIMIT);
    end else begin
      h = height_reg;
    end

    if (EW'(col) >= w) begin
      c0 = '0;
      r1 = HW'(row) + HW'(1);
    end else begin
      c0 = col;
      r1 = HW'(row);
    end
    r0 = (r1 >= h) ? '0 : r1;

    cn = EW'(c0) + EW'(1);
    rn = r0 + HW'(1);
    if (cn >= w) begin
      col_next = '0;
      row_next = (rn >= h) ? '0 : rn[ROW_W-1:0];
    end else begin
      col_next = CW'(cn);
      row_next = r0[ROW_W-1:0];
    end

    idx            = AW'(c0 >> 1);
    half_idx       = EW'(c0 >> 1) + EW'(1);
    info.odd_col   = c0[0];
    info.odd_row   = r0[0];
    info.row_end   = (half_idx == (w >> 1));
    info.frame_end = info.row_end && (({1'b0, r0} + (HW+1)'(2)) >= {1'b0, h});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (advance) begin
      col <= col_next;
      row <= row_next;
    end
  end

endmodule

FILE: hdl/rgbamp_line.sv
// Line store of pair maxima from the last even row of the RGBA 2x2 max pool.
// One write port, one registered read port. Depends on nothing.
module rgbamp_line #(
  parameter int DEPTH = 512,
  parameter int AW    = 9,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/rgba_max_pool_2x2.sv
// Top level of the RGBA 2x2 stride-2 max pool.
// Depends on rgbamp_pkg, rgbamp_pos and rgbamp_line.
//
// Usage:
//   Pixels enter on the s_ stream in raster order, one item per pixel.
//   Each 2x2 block gives one item on the m_ stream: the per-channel maximum
//   of red, green, blue and alpha, tlast on the last item of an output row
//   and tuser on the last item of the frame. Even rows and even columns
//   give no item; an odd last column or row is dropped.
//   image_width and image_height are written on the cfg_ port while idle.
// Timing:
//   One pixel is accepted per cycle while s_tready is high. Accepting the last
//   pixel of a block reads the line store into the middle stage; the output
//   register then loads from that stage when free, and m_tvalid rises with it.
//   A stage between the line store and the output register lets the next
//   item in while a result waits; s_tready drops only when both are full.
// Reset:
//   rst clears the position counters, the pixel hold and both stages and
//   restores the default size of 640 by 480. The line store is not cleared.
module rgba_max_pool_2x2 #(
  parameter int MAX_WIDTH = rgbamp_pkg::DEF_MAX_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  rgbamp_pkg::cfg_index_t        cfg_index,
  input  logic [rgbamp_pkg::CFG_W-1:0]  cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [rgbamp_pkg::PIX_W-1:0]  s_tdata,  // red_in, green_in, blue_in, alpha_in
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [rgbamp_pkg::PIX_W-1:0]  m_tdata,  // red_out, green_out, blue_out, alpha_out
  output logic                          m_tlast,  // row_end
  output logic                          m_tuser   // frame_end
);
  import rgbamp_pkg::*;

  localparam int DEPTH = (MAX_WIDTH / 2 > 0) ? MAX_WIDTH / 2 : 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic             accept;
  logic [AW-1:0]    idx;
  pos_info_t        info;
  logic [PIX_W-1:0] left_hold;
  logic [PIX_W-1:0] pair;
  logic [PIX_W-1:0] line_rdata;
  logic             line_we;
  logic             line_re;

  logic             s1_valid;
  logic [PIX_W-1:0] s1_pair;
  logic             s1_last;
  logic             s1_user;
  logic             s1_move;

  assign accept   = s_tvalid && s_tready;
  assign s1_move  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_move;
  assign pair     = chan_max(left_hold, s_tdata);
  assign line_we  = accept && info.odd_col && !info.odd_row;
  assign line_re  = accept && info.odd_col && info.odd_row;

  rgbamp_pos #(
    .MAX_WIDTH(MAX_WIDTH),
    .AW       (AW)
  ) u_pos (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .advance  (accept),
    .idx      (idx),
    .info     (info)
  );

  rgbamp_line #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .DW   (PIX_W)
  ) u_line (
    .clk  (clk),
    .we   (line_we),
    .waddr(idx),
    .wdata(pair),
    .re   (line_re),
    .raddr(idx),
    .rdata(line_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      left_hold <= '0;
    end else if (accept && !info.odd_col) begin
      left_hold <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= line_re;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (line_re) begin
      s1_pair <= pair;
      s1_last <= info.row_end;
      s1_user <= info.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_move) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      m_tdata <= chan_max(line_rdata, s1_pair);
      m_tlast <= s1_last;
      m_tuser <= s1_user;
    end
  end

endmodule

FILE: hdl/rgbamp_checker.sv
// Port-level checks of the RGBA 2x2 max pool, bound to the top level.
// Depends on rgbamp_pkg and rgba_max_pool_2x2_defines.svh.
`include "rgba_max_pool_2x2_defines.svh"

module rgbamp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          cfg_we,
  input rgbamp_pkg::cfg_index_t        cfg_index,
  input logic [rgbamp_pkg::CFG_W-1:0]  cfg_data,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [rgbamp_pkg::PIX_W-1:0]  s_tdata,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [rgbamp_pkg::PIX_W-1:0]  m_tdata,
  input logic                          m_tlast,
  input logic                          m_tuser
);
  import rgbamp_pkg::*;

  `RGBAMP_ASSERT(a_reset_empty, $past(rst) |-> !m_tvalid, "output valid after reset")
  `RGBAMP_ASSERT(a_hold_stall,
                 m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
                 $stable(m_tlast) && $stable(m_tuser),
                 "stalled item changed")
  `RGBAMP_ASSERT(a_frame_row, m_tvalid && m_tuser |-> m_tlast, "frame end off a row end")
  `RGBAMP_ASSERT(a_ready_empty, !m_tvalid |-> s_tready, "input stalled with output empty")

endmodule

bind rgba_max_pool_2x2 rgbamp_checker u_rgbamp_checker (.*);

FILE: tb/sv/pool_result_checker.sv
// Result checker for the RGBA 2x2 max pool: predicts every pooled item from the pixels
// and register writes it sees and compares each output item field by field.
// Depends on rgbamp_pkg.
module pool_result_checker
  import rgbamp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  cfg_index_t         cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               s_tvalid,
  input  logic               s_tready,
  input  logic [PIX_W-1:0]   s_tdata,   // red_in, green_in, blue_in, alpha_in
  input  logic               m_tvalid,
  input  logic               m_tready,
  input  logic [PIX_W-1:0]   m_tdata,   // red_out, green_out, blue_out, alpha_out
  input  logic               m_tlast,   // row_end
  input  logic               m_tuser,   // frame_end
  output int                 fail_count,
  output int                 pending
);

  localparam int LINE_ENTRIES = DEF_MAX_WIDTH / 2;

  typedef struct packed {
    logic [CHAN_W-1:0] alpha;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } rgba_t;

  typedef struct packed {
    rgba_t color;
    logic  row_end;
    logic  frame_end;
  } pooled_t;

  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;
  rgba_t               left_hold;
  rgba_t               pair_line [LINE_ENTRIES];
  int                  col_pos;
  int                  row_pos;
  pooled_t             pooled_q [$];
  int                  mismatches = 0;

  function automatic rgba_t brightest(input rgba_t a, input rgba_t b);
    rgba_t m;
    m.red   = (a.red   > b.red)   ? a.red   : b.red;
    m.green = (a.green > b.green) ? a.green : b.green;
    m.blue  = (a.blue  > b.blue)  ? a.blue  : b.blue;
    m.alpha = (a.alpha > b.alpha) ? a.alpha : b.alpha;
    return m;
  endfunction

  function automatic int width_in_use();
    if (width_reg < 2) return 2;
    if (width_reg > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
    return int'(width_reg);
  endfunction

  function automatic int height_in_use();
    if (height_reg < 2) return 2;
    if (height_reg > HEIGHT_LIMIT) return HEIGHT_LIMIT;
    return int'(height_reg);
  endfunction

  task automatic pool_pixel(input rgba_t px);
    int      w;
    int      h;
    int      col;
    int      row;
    int      k;
    rgba_t   pair;
    pooled_t res;
    w = width_in_use();
    h = height_in_use();
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    col = col_pos;
    row = row_pos;
    if (col % 2 == 0) begin
      left_hold = px;
    end else begin
      k = col / 2;
      pair = brightest(left_hold, px);
      if (row % 2 == 0) begin
        pair_line[k] = pair;
      end else begin
        res.color     = brightest(pair_line[k], pair);
        res.row_end   = (k + 1 == w / 2);
        res.frame_end = res.row_end && (row + 2 >= h);
        pooled_q.push_back(res);
      end
    end
    col_pos = col + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = row + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  task automatic check_field(input string name, input logic [CHAN_W-1:0] want,
                             input logic [CHAN_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result(input rgba_t got, input logic got_row_end,
                              input logic got_frame_end);
    pooled_t want;
    if (pooled_q.size() == 0) begin
      $error("unexpected item: color %h row_end %b frame_end %b",
             got, got_row_end, got_frame_end);
      mismatches++;
    end else begin
      want = pooled_q.pop_front();
      check_field("red_out", want.color.red, got.red);
      check_field("green_out", want.color.green, got.green);
      check_field("blue_out", want.color.blue, got.blue);
      check_field("alpha_out", want.color.alpha, got.alpha);
      check_field("row_end", CHAN_W'(want.row_end), CHAN_W'(got_row_end));
      check_field("frame_end", CHAN_W'(want.frame_end), CHAN_W'(got_frame_end));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      left_hold  = '0;
      col_pos    = 0;
      row_pos    = 0;
      pooled_q.delete();
    end else begin
      if (m_tvalid && m_tready) check_result(m_tdata, m_tlast, m_tuser);
      if (cfg_we) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH: width_reg = cfg_data[WIDTH_W-1:0];
          CFG_IMAGE_HEIGHT: height_reg = cfg_data[HEIGHT_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) pool_pixel(s_tdata);
    end
    pending    <= pooled_q.size();
    fail_count <= mismatches;
  end

endmodule

FILE: tb/sv/testbench.sv
// Top of the RGBA 2x2 max pool testbench: clock, reset, register writes and pixel
// stimulus with random idling on both streams, then the verdict.
// Depends on rgbamp_pkg, rgba_max_pool_2x2 and pool_result_checker.
module testbench;
  import rgbamp_pkg::*;

  localparam int RANDOM_ITEMS = 500;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  cfg_index_t       cfg_index = CFG_IMAGE_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [PIX_W-1:0] s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [PIX_W-1:0] m_tdata;
  logic             m_tlast;
  logic             m_tuser;
  int               fail_count;
  int               pending;

  bit steady_in = 1'b0;
  bit steady_out = 1'b0;
  int ready_hold = 0;
  int items_sent = 0;
  int col_next = 0;
  int row_next = 0;
  int width_used = int'(WIDTH_RESET);
  int height_used = int'(HEIGHT_RESET);

  always #10 clk = ~clk;

  rgba_max_pool_2x2 dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  pool_result_checker result_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  function automatic int stall_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(5, 30);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [PIX_W-1:0] rgba(input logic [CHAN_W-1:0] r, g, b, a);
    return {a, b, g, r};
  endfunction

  function automatic logic [PIX_W-1:0] random_pixel();
    logic [PIX_W-1:0] px;
    px = $urandom;
    if ($urandom_range(0, 7) == 0) begin
      for (int c = 0; c < CHANNELS; c++) begin
        case ($urandom_range(0, 2))
          0: px[c*CHAN_W +: CHAN_W] = '0;
          1: px[c*CHAN_W +: CHAN_W] = '1;
          default: ;
        endcase
      end
    end
    return px;
  endfunction

  function automatic int clamp_width(input logic [CFG_W-1:0] v);
    int w;
    w = int'(v[WIDTH_W-1:0]);
    if (w < 2) return 2;
    if (w > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
    return w;
  endfunction

  function automatic int clamp_height(input logic [CFG_W-1:0] v);
    int h;
    h = int'(v[HEIGHT_W-1:0]);
    if (h < 2) return 2;
    if (h > HEIGHT_LIMIT) return HEIGHT_LIMIT;
    return h;
  endfunction

  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (!steady_out && $urandom_range(0, 3) == 0) ready_hold = stall_len();
    end
  end

  // track the position of the next pixel so a width raise never reads stale line entries
  task automatic send_pixel(input logic [PIX_W-1:0] px);
    if (!steady_in && $urandom_range(0, 1) == 0) begin
      s_tvalid <= 1'b0;
      repeat (stall_len()) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    if (col_next >= width_used) begin
      col_next = 0;
      row_next++;
    end
    if (row_next >= height_used) row_next = 0;
    col_next++;
    if (col_next >= width_used) begin
      col_next = 0;
      row_next++;
      if (row_next >= height_used) row_next = 0;
    end
  endtask

  task automatic send_frame_rest();
    do send_pixel(random_pixel()); while (col_next != 0 || row_next != 0);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic configure(input bit set_w, input logic [CFG_W-1:0] w_val,
                           input bit set_h, input logic [CFG_W-1:0] h_val);
    int new_w;
    new_w = set_w ? clamp_width(w_val) : width_used;
    // finish an odd row before widening
    if (new_w > width_used) begin
      while (row_next % 2 != 0) send_pixel(random_pixel());
    end
    wait_idle();
    if (set_w) begin
      write_reg(CFG_IMAGE_WIDTH, w_val);
      width_used = new_w;
    end
    if (set_h) begin
      write_reg(CFG_IMAGE_HEIGHT, h_val);
      height_used = clamp_height(h_val);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    int goal;
    logic [CFG_W-1:0] big_width;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // default size, then shrink so the next pixel wraps into an odd row
    send_pixel(rgba(8'hFF, 8'h00, 8'h00, 8'h00));
    send_pixel(rgba(8'h00, 8'hFF, 8'h00, 8'h00));
    configure(1'b1, 13'd2, 1'b1, 13'd2);
    send_pixel(rgba(8'h00, 8'h00, 8'hFF, 8'h00));
    send_pixel(rgba(8'h00, 8'h00, 8'h00, 8'hFF));
    send_pixel(rgba(8'h01, 8'h80, 8'h7F, 8'hFE));
    send_pixel(rgba(8'h80, 8'h01, 8'hFE, 8'h7F));
    send_pixel(rgba(8'h7F, 8'hFE, 8'h01, 8'h80));
    send_pixel(rgba(8'hFE, 8'h7F, 8'h80, 8'h01));
    // odd width and odd height
    configure(1'b1, 13'd3, 1'b1, 13'd3);
    repeat (9) send_pixel(random_pixel());
    // below range on both registers
    configure(1'b1, 13'd0, 1'b1, 13'd1);
    repeat (4) send_pixel(rgba(8'h00, 8'h00, 8'h00, 8'h00));

    case ($urandom_range(0, 3))
      0: big_width = 13'd1023;
      1: big_width = 13'd1024;
      2: big_width = 13'd1025;
      default: big_width = 13'd2047;
    endcase
    // part of an even row at a large width, then shrink so the rest wraps into the odd row
    configure(1'b1, big_width, 1'b1, 13'd2);
    repeat (24) send_pixel(random_pixel());
    configure(1'b1, 13'd8, 1'b0, '0);
    send_frame_rest();

    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      steady_in = ($urandom_range(0, 4) == 0);
      steady_out <= ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: configure(1'b1, CFG_W'($urandom_range(2, 12)),
                                 1'b1, CFG_W'($urandom_range(2, 6)));
        5: configure(1'b1, CFG_W'($urandom_range(2, 12)), 1'b0, '0);
        6: configure(1'b0, '0, 1'b1, CFG_W'($urandom_range(2, 6)));
        7: configure(1'b1, CFG_W'($urandom_range(0, 3)) |
                           ($urandom_range(0, 1) ? 13'h1800 : 13'h0),
                     1'b1, CFG_W'($urandom_range(0, 3)));
        8: configure(1'b1, CFG_W'($urandom_range(2, 12)), 1'b1,
                     $urandom_range(0, 1) ? CFG_W'($urandom_range(4095, 4097)) : 13'h1FFF);
        default: ;
      endcase
      if (width_used * height_used <= 200 && $urandom_range(0, 3) != 0) send_frame_rest();
      else repeat ($urandom_range(1, 40)) send_pixel(random_pixel());
    end

    steady_out <= 1'b0;
    wait_idle();
    repeat (6) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
